// ===== sv/rrt_pkg.sv =====
package rrt_pkg;

	localparam int CW = 16;
	localparam int IW = 10;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_PATH   = 2'd2;

	localparam logic [2:0] ST_STARTED  = 3'd0;
	localparam logic [2:0] ST_ADDED    = 3'd1;
	localparam logic [2:0] ST_GOAL     = 3'd2;
	localparam logic [2:0] ST_OBSTACLE = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;
	localparam logic [2:0] ST_PATH     = 3'd5;
	localparam logic [2:0] ST_NOPATH   = 3'd6;

	localparam logic [1:0] REG_GOAL_X  = 2'd0;
	localparam logic [1:0] REG_GOAL_Y  = 2'd1;
	localparam logic [1:0] REG_RADIUS  = 2'd2;
	localparam logic [1:0] REG_ITER    = 2'd3;

	typedef struct packed {
		logic [1:0]           op;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 sample_free;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic signed [CW-1:0] node_x;
		logic signed [CW-1:0] node_y;
		logic [IW-1:0]        node_index;
		logic [IW-1:0]        parent_index;
		logic                 last;
	} out_item_t;

endpackage

// ===== sv/rrt_dist_unit.sv =====
// Squared distance, two stages: absolute differences, then squares and sum.
module rrt_dist_unit import rrt_pkg::*; (
	input  logic                 clk,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	output logic [2*CW:0]        dsq
);
	logic [CW:0] dx_s1, dy_s1;
	logic signed [CW:0] ex, ey;
	logic [2*CW-1:0] sqx, sqy;

	always_comb begin
		ex = {ax[CW-1], ax} - {bx[CW-1], bx};
		ey = {ay[CW-1], ay} - {by[CW-1], by};
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ex[CW] ? -ex : ex;
		dy_s1 <= ey[CW] ? -ey : ey;
	end

	assign sqx = dx_s1[CW-1:0] * dx_s1[CW-1:0];
	assign sqy = dy_s1[CW-1:0] * dy_s1[CW-1:0];

	always_ff @(posedge clk) begin
		dsq <= {1'b0, sqx} + {1'b0, sqy}
			+ ({(2*CW+1){dx_s1[CW]}} & (2*CW+1)'(1) << (2*CW))
			+ ({(2*CW+1){dy_s1[CW]}} & (2*CW+1)'(1) << (2*CW));
	end
endmodule

// ===== sv/rrt_tree_growth_engine_core.sv =====
// RRT tree growth engine.
// Items enter on start with in_item; accepted when start is high and busy low.
// op start clears the tree and stores node 0; op sample scans all stored nodes
// for the nearest (squared distance, lowest index wins ties) and appends the
// sample if free; op path returns the next point walking from goal to start.
// Each item gives exactly one result on out_item, marked by done for one
// cycle; the receiver cannot stall it.
// Start, ignored and no-path items give their result in the cycle after the
// transfer; a path point passes through the PATH state first. A sample's scan
// grows with the node count, set by the single distance unit stepping one
// stored node per cycle through a read-registered node memory; an obstacle gives
// its result from GOAL1, an added sample from GOAL3 after GOAL2. busy drops in the cycle the result is shown.
// Configuration goes through the APB port (goal_x, goal_y, goal_radius_sq,
// iteration_limit at byte addresses 0, 4, 8, 12); write only while idle.
// Reset clears control state and registers to defaults; the node memory is
// not cleared since only written entries are ever read.
module rrt_tree_growth_engine_core import rrt_pkg::*; #(
	parameter int MAX_NODES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_item_t    in_item,
	output logic        busy,
	output logic        done,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(MAX_NODES);
	localparam int NW = AW + 1;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_GOAL1, S_GOAL2, S_GOAL3, S_PATH}
		state_t;
	state_t state_q, state_d;

	logic signed [CW-1:0] goal_x_q, goal_y_q;
	logic [29:0]          radius_q;
	logic [15:0]          iter_q;

	logic signed [CW-1:0] mem_x [MAX_NODES];
	logic signed [CW-1:0] mem_y [MAX_NODES];
	logic [AW-1:0]        mem_p [MAX_NODES];
	logic signed [CW-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0]        rd_p_q;

	logic [NW-1:0]        node_count_q, node_count_d;
	logic [15:0]          samples_q, samples_d;
	logic                 goal_found_q, trace_active_q;
	logic                 goal_found_d, trace_active_d;
	logic [AW-1:0]        trace_q, trace_d;
	logic signed [CW-1:0] sx_q, sy_q, sx_d, sy_d;
	logic                 free_q, free_d;

	logic [NW-1:0]        rd_cnt_q, rd_cnt_d;
	logic [NW-1:0]        cmp_cnt_q, cmp_cnt_d;
	logic [2:0]           vld_q, vld_d;
	logic [2*CW:0]        best_q, best_d;
	logic [AW-1:0]        best_idx_q, best_idx_d;
	logic                 done_d;
	out_item_t            out_d;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic signed [CW-1:0] ux, uy;
	logic [2*CW:0]        dsq;

	assign pready = 1'b1;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		case (paddr[3:2])
			REG_GOAL_X: prdata = 32'(unsigned'(goal_x_q));
			REG_GOAL_Y: prdata = 32'(unsigned'(goal_y_q));
			REG_RADIUS: prdata = {2'b0, radius_q};
			REG_ITER:   prdata = {16'b0, iter_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			radius_q <= 30'd2500;
			iter_q   <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_GOAL_X: goal_x_q <= pwdata[CW-1:0];
				REG_GOAL_Y: goal_y_q <= pwdata[CW-1:0];
				REG_RADIUS: radius_q <= pwdata[29:0];
				REG_ITER:   iter_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign wr_addr = (start && !busy && in_item.op == OP_START) ? '0 : node_count_q[AW-1:0];
	assign wr_en = (start && !busy && in_item.op == OP_START) ||
		(state_q == S_GOAL1 && free_q);
	assign rd_addr = (state_q == S_SCAN) ? rd_cnt_q[AW-1:0] : trace_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= (state_q == S_IDLE) ? in_item.x : sx_q;
			mem_y[wr_addr] <= (state_q == S_IDLE) ? in_item.y : sy_q;
			mem_p[wr_addr] <= (state_q == S_IDLE) ? '0 : best_idx_q;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		rd_p_q <= mem_p[rd_addr];
	end

	// unit compares sample against node data during scan, against goal after
	assign ux = (state_q == S_SCAN || state_q == S_DRAIN) ? rd_x_q : goal_x_q;
	assign uy = (state_q == S_SCAN || state_q == S_DRAIN) ? rd_y_q : goal_y_q;

	rrt_dist_unit u_dist (
		.clk (clk), .ax (sx_q), .ay (sy_q), .bx (ux), .by (uy), .dsq (dsq)
	);

	always_comb begin
		state_d        = state_q;
		done_d         = 1'b0;
		out_d          = out_item;
		node_count_d   = node_count_q;
		samples_d      = samples_q;
		goal_found_d   = goal_found_q;
		trace_active_d = trace_active_q;
		trace_d        = trace_q;
		sx_d           = sx_q;
		sy_d           = sy_q;
		free_d         = free_q;
		rd_cnt_d       = rd_cnt_q;
		cmp_cnt_d      = cmp_cnt_q;
		vld_d          = vld_q;
		best_d         = best_q;
		best_idx_d     = best_idx_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					done_d       = 1'b1;
					out_d        = '0;
					out_d.status = ST_IGNORED;
					case (in_item.op)
						OP_START: begin
							node_count_d   = NW'(1);
							samples_d      = '0;
							goal_found_d   = 1'b0;
							trace_active_d = 1'b0;
							trace_d        = '0;
							out_d.status   = ST_STARTED;
							out_d.node_x   = in_item.x;
							out_d.node_y   = in_item.y;
						end
						OP_SAMPLE: begin
							if (!(node_count_q == '0 || goal_found_q ||
								samples_q >= iter_q ||
								node_count_q >= NW'(MAX_NODES))) begin
								done_d    = 1'b0;
								samples_d = samples_q + 16'd1;
								sx_d      = in_item.x;
								sy_d      = in_item.y;
								free_d    = in_item.sample_free;
								rd_cnt_d  = '0;
								cmp_cnt_d = '0;
								vld_d     = '0;
								state_d   = S_SCAN;
							end
						end
						OP_PATH: begin
							if (trace_active_q) begin
								done_d  = 1'b0;
								state_d = S_PATH;
							end else begin
								out_d.status = ST_NOPATH;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN, S_DRAIN: begin
				// read stage, then two distance stages
				vld_d = {vld_q[1:0], (state_q == S_SCAN)};
				if (state_q == S_SCAN) begin
					rd_cnt_d = rd_cnt_q + NW'(1);
					if (rd_cnt_q + NW'(1) == node_count_q)
						state_d = S_DRAIN;
				end
				if (vld_q[2]) begin
					if (cmp_cnt_q == '0 || dsq < best_q) begin
						best_d     = dsq;
						best_idx_d = cmp_cnt_q[AW-1:0];
					end
					cmp_cnt_d = cmp_cnt_q + NW'(1);
					if (cmp_cnt_q + NW'(1) == node_count_q)
						state_d = S_GOAL1;
				end
			end
			S_GOAL1: begin
				// node write happens here; goal distance in flight
				if (!free_q) begin
					done_d             = 1'b1;
					out_d              = '0;
					out_d.status       = ST_OBSTACLE;
					out_d.node_x       = sx_q;
					out_d.node_y       = sy_q;
					out_d.parent_index = IW'(best_idx_q);
					state_d            = S_IDLE;
				end else begin
					state_d = S_GOAL2;
				end
			end
			S_GOAL2: state_d = S_GOAL3;
			S_GOAL3: begin
				done_d             = 1'b1;
				out_d              = '0;
				out_d.node_x       = sx_q;
				out_d.node_y       = sy_q;
				out_d.node_index   = IW'(node_count_q[AW-1:0]);
				out_d.parent_index = IW'(best_idx_q);
				node_count_d       = node_count_q + NW'(1);
				if (dsq < {3'b0, radius_q}) begin
					out_d.status   = ST_GOAL;
					goal_found_d   = 1'b1;
					trace_active_d = 1'b1;
					trace_d        = node_count_q[AW-1:0];
				end else begin
					out_d.status = ST_ADDED;
				end
				state_d = S_IDLE;
			end
			S_PATH: begin
				// read data for trace_q now registered
				done_d             = 1'b1;
				out_d.status       = ST_PATH;
				out_d.node_x       = rd_x_q;
				out_d.node_y       = rd_y_q;
				out_d.node_index   = IW'(trace_q);
				out_d.parent_index = IW'(rd_p_q);
				out_d.last         = (trace_q == '0);
				if (trace_q == '0)
					trace_active_d = 1'b0;
				else
					trace_d = rd_p_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done           <= 1'b0;
			out_item       <= '0;
			node_count_q   <= '0;
			samples_q      <= '0;
			goal_found_q   <= 1'b0;
			trace_active_q <= 1'b0;
			trace_q        <= '0;
			sx_q           <= '0;
			sy_q           <= '0;
			free_q         <= 1'b0;
			rd_cnt_q       <= '0;
			cmp_cnt_q      <= '0;
			vld_q          <= '0;
			best_q         <= '0;
			best_idx_q     <= '0;
		end else begin
			state_q        <= state_d;
			done           <= done_d;
			out_item       <= out_d;
			node_count_q   <= node_count_d;
			samples_q      <= samples_d;
			goal_found_q   <= goal_found_d;
			trace_active_q <= trace_active_d;
			trace_q        <= trace_d;
			sx_q           <= sx_d;
			sy_q           <= sy_d;
			free_q         <= free_d;
			rd_cnt_q       <= rd_cnt_d;
			cmp_cnt_q      <= cmp_cnt_d;
			vld_q          <= vld_d;
			best_q         <= best_d;
			best_idx_q     <= best_idx_d;
		end
	end
endmodule

// ===== verif/rrt_tree_growth_engine_core_test.sv =====
`timescale 1ns / 1ps

module rrt_tree_growth_engine_core_test;
	import rrt_pkg::*;

	localparam int NODES = 1024;
	localparam longint CYCLE_LIMIT = 64'd2000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	in_item_t    in_item;
	logic        busy;
	logic        done;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rrt_tree_growth_engine_core #(.MAX_NODES(NODES)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item), .busy(busy),
		.done(done), .out_item(out_item), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// predictor state
	logic signed [CW-1:0] tree_x [NODES];
	logic signed [CW-1:0] tree_y [NODES];
	logic [IW-1:0]        tree_parent [NODES];
	int unsigned          tree_count;
	int unsigned          samples_taken;
	bit                   goal_reached;
	logic [IW-1:0]        walk_ptr;
	bit                   walk_active;
	logic signed [CW-1:0] cfg_goal_x;
	logic signed [CW-1:0] cfg_goal_y;
	logic [29:0]          cfg_radius_sq;
	logic [15:0]          cfg_iter_limit;

	out_item_t expected_results [$];
	int        failures;
	int        items_sent;
	int        results_seen;
	int        goals_seen;
	longint    cycle_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rrt_tree_growth_engine_core_test failed");
			$finish;
		end
	end

	function automatic longint unsigned dist_sq(logic signed [CW-1:0] ax,
		logic signed [CW-1:0] ay, logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return longint'(dx * dx) + longint'(dy * dy);
	endfunction

	function automatic out_item_t mk(logic [2:0] st, logic signed [CW-1:0] px,
		logic signed [CW-1:0] py, logic [IW-1:0] idx, logic [IW-1:0] par, logic lst);
		out_item_t r;
		r.status = st; r.node_x = px; r.node_y = py;
		r.node_index = idx; r.parent_index = par; r.last = lst;
		return r;
	endfunction

	function automatic out_item_t predict_tree_step(in_item_t it);
		int unsigned best;
		longint unsigned bd;
		longint unsigned d;
		int unsigned n;
		logic [IW-1:0] p;
		case (it.op)
			OP_START: begin
				tree_x[0] = it.x; tree_y[0] = it.y; tree_parent[0] = '0;
				tree_count = 1; samples_taken = 0; goal_reached = 0;
				walk_ptr = '0; walk_active = 0;
				return mk(ST_STARTED, it.x, it.y, '0, '0, 1'b0);
			end
			OP_SAMPLE: begin
				if (tree_count == 0 || goal_reached || samples_taken >= cfg_iter_limit
						|| tree_count >= NODES)
					return mk(ST_IGNORED, '0, '0, '0, '0, 1'b0);
				samples_taken++;
				best = 0;
				bd = dist_sq(it.x, it.y, tree_x[0], tree_y[0]);
				for (int i = 1; i < tree_count; i++) begin
					d = dist_sq(it.x, it.y, tree_x[i], tree_y[i]);
					if (d < bd) begin
						bd = d; best = i;
					end
				end
				if (!it.sample_free)
					return mk(ST_OBSTACLE, it.x, it.y, '0, best[IW-1:0], 1'b0);
				n = tree_count;
				tree_x[n] = it.x; tree_y[n] = it.y; tree_parent[n] = best[IW-1:0];
				tree_count = n + 1;
				if (dist_sq(it.x, it.y, cfg_goal_x, cfg_goal_y) < longint'(cfg_radius_sq)) begin
					goal_reached = 1; walk_ptr = n[IW-1:0]; walk_active = 1;
					return mk(ST_GOAL, it.x, it.y, n[IW-1:0], best[IW-1:0], 1'b0);
				end
				return mk(ST_ADDED, it.x, it.y, n[IW-1:0], best[IW-1:0], 1'b0);
			end
			OP_PATH: begin
				if (!walk_active)
					return mk(ST_NOPATH, '0, '0, '0, '0, 1'b0);
				p = walk_ptr;
				if (p == 0)
					walk_active = 0;
				else
					walk_ptr = tree_parent[p];
				return mk(ST_PATH, tree_x[p], tree_y[p], p, tree_parent[p], p == 0);
			end
			default: return mk(ST_IGNORED, '0, '0, '0, '0, 1'b0);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: status %0d", out_item.status);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (out_item.status == ST_GOAL)
					goals_seen++;
				if (out_item.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, out_item.status);
					failures++;
				end
				if (out_item.node_x !== want.node_x) begin
					$error("node_x: expected %0d actual %0d", want.node_x, out_item.node_x);
					failures++;
				end
				if (out_item.node_y !== want.node_y) begin
					$error("node_y: expected %0d actual %0d", want.node_y, out_item.node_y);
					failures++;
				end
				if (out_item.node_index !== want.node_index) begin
					$error("node_index: expected %0d actual %0d", want.node_index,
						out_item.node_index);
					failures++;
				end
				if (out_item.parent_index !== want.parent_index) begin
					$error("parent_index: expected %0d actual %0d", want.parent_index,
						out_item.parent_index);
					failures++;
				end
				if (out_item.last !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, out_item.last);
					failures++;
				end
			end
		end
	end

	// with no gap, start stays high for the next item
	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 9) < 4)
			return;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		start <= 1'b0;
		in_item <= in_item_t'({$urandom(), 3'($urandom_range(0, 7))});
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(logic [1:0] op, logic signed [CW-1:0] x,
		logic signed [CW-1:0] y, logic fr);
		in_item_t it;
		it.op = op; it.x = x; it.y = y; it.sample_free = fr;
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.insert(expected_results.size(), predict_tree_step(it));
		items_sent++;
		idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		in_item <= in_item_t'({$urandom(), 3'($urandom_range(0, 7))});
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_GOAL_X: cfg_goal_x = val[15:0];
			REG_GOAL_Y: cfg_goal_y = val[15:0];
			REG_RADIUS: cfg_radius_sq = val[29:0];
			default: cfg_iter_limit = val[15:0];
		endcase
	endtask

	task automatic configure(logic signed [15:0] gx, logic signed [15:0] gy,
		logic [29:0] rad, logic [15:0] lim);
		drain();
		write_reg(REG_GOAL_X, {16'($urandom_range(0, 65535)), gx});
		write_reg(REG_GOAL_Y, {16'hffff, gy});
		write_reg(REG_RADIUS, {2'b11, rad});
		write_reg(REG_ITER, {16'h5a5a, lim});
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic test_directed();
		send_item(OP_SAMPLE, 16'sd5, 16'sd5, 1'b1);     // before any start
		send_item(OP_PATH, '0, '0, 1'b0);               // no walk
		send_item(2'd3, 16'sh7fff, -16'sd1, 1'b1);      // unknown op
		configure(16'sd0, 16'sd0, 30'd2500, 16'd5);
		send_item(OP_START, 16'sh8000, 16'sd32767, 1'b0);
		send_item(OP_SAMPLE, 16'sd32767, 16'sh8000, 1'b1);  // widest distance
		send_item(OP_SAMPLE, 16'sd32767, 16'sh8000, 1'b0);  // same point as node 1: distance zero, obstacle
		send_item(OP_SAMPLE, 16'sd0, 16'sd0, 1'b0);
		send_item(OP_SAMPLE, 16'sd0, 16'sd0, 1'b0);
		send_item(OP_SAMPLE, 16'sd0, 16'sd0, 1'b0);
		send_item(OP_SAMPLE, 16'sd0, 16'sd0, 1'b1);     // past the limit
		send_item(OP_PATH, '0, '0, 1'b0);
		configure(16'sd100, -16'sd100, 30'd2500, 16'd65535);
		send_item(OP_START, 16'sd100, -16'sd100, 1'b1);  // start on goal, not tested
		send_item(OP_SAMPLE, 16'sd150, -16'sd100, 1'b1); // exactly on radius
		send_item(OP_SAMPLE, 16'sd149, -16'sd100, 1'b1); // inside
		send_item(OP_SAMPLE, 16'sd1, 16'sd1, 1'b1);      // goal already reached
		repeat (4) send_item(OP_PATH, '0, '0, 1'b0);     // walk past start
		configure(16'sd0, 16'sd0, 30'd0, 16'd0);
		send_item(OP_START, '0, '0, 1'b0);
		send_item(OP_SAMPLE, '0, '0, 1'b1);              // limit zero
	endtask

	task automatic test_deep_tree();
		configure(16'sh7fff, 16'sh7fff, 30'd0, 16'd65535);
		send_item(OP_START, '0, '0, 1'b1);
		for (int i = 0; i < 300; i++)
			send_item(OP_SAMPLE, 16'($urandom_range(0, 63) - 32),
				16'($urandom_range(0, 63) - 32), 1'b1);
	endtask

	task automatic random_plan(int n_samples);
		int r;
		send_item(OP_START, 16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
		for (int i = 0; i < n_samples; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_item(2'd3, 16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
			else if (r == 1)
				send_item(OP_PATH, 16'($urandom()), 16'($urandom()),
					1'($urandom_range(0, 1)));
			else if (r < 10)
				send_item(OP_SAMPLE, 16'(cfg_goal_x + $urandom_range(0, 400) - 200),
					16'(cfg_goal_y + $urandom_range(0, 400) - 200),
					$urandom_range(0, 5) != 0);
			else
				send_item(OP_SAMPLE, 16'($urandom()), 16'($urandom()),
					$urandom_range(0, 5) != 0);
		end
		repeat ($urandom_range(0, 12))
			send_item(OP_PATH, 16'($urandom()), 16'($urandom()), 1'b0);
	endtask

	task automatic test_random();
		configure(16'($urandom()), 16'($urandom()), 30'($urandom_range(1000, 40000)),
			16'd1000);
		repeat (4) random_plan(20);
		configure(16'($urandom()), 16'($urandom()), 30'h3fffffff, 16'd30);
		repeat (2) random_plan(15);
		configure(16'($urandom()), 16'($urandom()), 30'($urandom_range(0, 90000)),
			16'($urandom_range(5, 40)));
		repeat (3) random_plan(20);
		configure(16'($urandom()), 16'($urandom()), 30'd2500, 16'd1000);
		repeat (1) random_plan(25);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cycle_count = 0; failures = 0; items_sent = 0; results_seen = 0; goals_seen = 0;
		tree_count = 0; samples_taken = 0; goal_reached = 0; walk_ptr = '0; walk_active = 0;
		cfg_goal_x = 0; cfg_goal_y = 0; cfg_radius_sq = 30'd2500; cfg_iter_limit = 16'd1000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deep_tree();
		test_random();
		drain();
		$display("covered %0d items, %0d results, %0d goal captures, deep tree scans and limits",
			items_sent, results_seen, goals_seen);
		if (failures == 0 && expected_results.size() == 0)
			$display("rrt_tree_growth_engine_core_test passed");
		else
			$display("rrt_tree_growth_engine_core_test failed");
		$finish;
	end

endmodule
